>>> src/ptts_pkg.sv
// shared types and codes for the periodic task tick scheduler
`default_nettype none
package ptts_pkg;

    localparam logic [1:0] MODE_TICK     = 2'd0;
    localparam logic [1:0] MODE_DISPATCH = 2'd1;
    localparam logic [1:0] MODE_LOAD     = 2'd2;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;

    localparam int MAX_RESULTS  = 16;
    localparam int RESULT_CNT_W = 5;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  slot_index;
        logic [15:0] interval_value;
        logic        suspend_value;
    } in_beat_t;

    typedef struct packed {
        logic [3:0] task_index;
        logic       none_ready;
        logic       last;
    } out_beat_t;

    // per-step controls handed to the slot operator
    typedef struct packed {
        logic [1:0] mode;
        logic       load_hit;
        logic       load_suspend;
        logic       can_dispatch;
    } op_ctrl_t;

endpackage
`default_nettype wire

>>> src/periodic_task_tick_scheduler.sv
// top level: ring of slot cells, head operator, pass sequencer and result register
//
// The slots live in a ring of NUM_SLOTS cells that rotates one place per cycle
// during a pass; the slot leaving the head is updated and re-enters at the tail,
// so after NUM_SLOTS shifts every slot is back in its own cell. A tick or load
// beat is accepted and then walks the ring once, one slot per shift. A dispatch
// beat ends with a flush state after the walk: each found slot is held back
// until the next find or the flush so the final result of the pass can carry last,
// and the ring only moves while the result register can take a beat. A dispatch
// emits at most 16 results, in slot order, or one none-ready result. Mode 3 is
// accepted and dropped; a load to a slot number of NUM_SLOTS or more is dropped.
`default_nettype none
module periodic_task_tick_scheduler #(
    parameter int NUM_SLOTS   = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire ptts_pkg::in_beat_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output ptts_pkg::out_beat_t      m_data
);

    localparam int SLOT_W = 2 * COUNT_WIDTH + 2;
    localparam int STEP_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [STEP_W-1:0]            step_reg, step_next;
    ptts_pkg::in_beat_t           item_reg, item_next;
    logic [ptts_pkg::RESULT_CNT_W-1:0] found_reg, found_next;
    logic                         hold_valid_reg, hold_valid_next;
    logic [3:0]                   hold_idx_reg, hold_idx_next;
    logic                         m_valid_reg, m_valid_next;
    ptts_pkg::out_beat_t          m_data_reg, m_data_next;

    logic                         out_free;
    logic                         shift_en;
    logic                         last_step;
    logic                         fire;
    ptts_pkg::op_ctrl_t           op_ctrl;
    logic [SLOT_W-1:0]            head_new;
    logic [SLOT_W-1:0]            ring [NUM_SLOTS];
    logic [SLOT_W-1:0]            ring_in [NUM_SLOTS];

    assign out_free  = !m_valid_reg || m_ready;
    assign last_step = (step_reg == STEP_W'(NUM_SLOTS - 1));
    assign shift_en  = (state_reg == ST_RUN) &&
                       ((item_reg.mode != ptts_pkg::MODE_DISPATCH) || out_free);

    always_comb begin
        op_ctrl.mode         = item_reg.mode;
        op_ctrl.load_hit     = (8'(item_reg.slot_index) == 8'(step_reg));
        op_ctrl.load_suspend = item_reg.suspend_value;
        op_ctrl.can_dispatch =
            (found_reg < ptts_pkg::RESULT_CNT_W'(ptts_pkg::MAX_RESULTS));
    end

    ptts_slot_op #(
        .CW (COUNT_WIDTH)
    ) u_op (
        .slot_in    (ring[0]),
        .ctrl       (op_ctrl),
        .load_value (COUNT_WIDTH'(item_reg.interval_value)),
        .slot_out   (head_new),
        .fire       (fire)
    );

    genvar gi;
    generate
        for (gi = 0; gi < NUM_SLOTS; gi++) begin : g_cell
            if (gi == NUM_SLOTS - 1) begin : g_tail
                assign ring_in[gi] = head_new;
            end else begin : g_mid
                assign ring_in[gi] = ring[gi+1];
            end
            ptts_cell #(
                .SLOT_W (SLOT_W)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .din      (ring_in[gi]),
                .dout     (ring[gi])
            );
        end
    endgenerate

    always_comb begin
        state_next      = state_reg;
        step_next       = step_reg;
        item_next       = item_reg;
        found_next      = found_reg;
        hold_valid_next = hold_valid_reg;
        hold_idx_next   = hold_idx_reg;
        m_valid_next    = m_ready ? 1'b0 : m_valid_reg;
        m_data_next     = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next       = s_data;
                    step_next       = '0;
                    found_next      = '0;
                    hold_valid_next = 1'b0;
                    if (s_data.mode != ptts_pkg::MODE_UNUSED) begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (shift_en) begin
                    if (fire) begin
                        // previous find is not the final one, send it now
                        if (hold_valid_reg) begin
                            m_valid_next           = 1'b1;
                            m_data_next.task_index = hold_idx_reg;
                            m_data_next.none_ready = 1'b0;
                            m_data_next.last       = 1'b0;
                        end
                        hold_valid_next = 1'b1;
                        hold_idx_next   = 4'(step_reg);
                        found_next      = found_reg + 1'b1;
                    end
                    if (last_step) begin
                        step_next  = '0;
                        state_next = (item_reg.mode == ptts_pkg::MODE_DISPATCH) ?
                                     ST_FLUSH : ST_IDLE;
                    end else begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.task_index = hold_valid_reg ? hold_idx_reg : 4'd0;
                    m_data_next.none_ready = !hold_valid_reg;
                    m_data_next.last       = 1'b1;
                    hold_valid_next        = 1'b0;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            found_reg      <= '0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            found_reg      <= found_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        hold_idx_reg <= hold_idx_next;
        m_data_reg   <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a new result beat only comes out of a pass
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_RUN || $past(state_reg) == ST_FLUSH))
        else $error("result beat raised outside a pass");

    // a pass never finds more than the result limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg <= ptts_pkg::RESULT_CNT_W'(ptts_pkg::MAX_RESULTS))
        else $error("dispatch found count over limit");

    // none-ready only on the closing beat of a pass
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.none_ready |-> m_data_reg.last)
        else $error("none-ready beat without last");

    // the ring is parked in its home position whenever a beat can be taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> step_reg == '0)
        else $error("ring not at home while idle");

endmodule
`default_nettype wire

>>> src/ptts_cell.sv
// one slot cell of the rotating ring: holds a slot and passes it on when shifted
`default_nettype none
module ptts_cell #(
    parameter int SLOT_W = 34
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              shift_en,
    input  wire logic [SLOT_W-1:0] din,
    output logic      [SLOT_W-1:0] dout
);

    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;

    always_comb begin
        slot_next = shift_en ? din : slot_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
        end else begin
            slot_reg <= slot_next;
        end
    end

    assign dout = slot_reg;

endmodule
`default_nettype wire

>>> src/ptts_slot_op.sv
// tick, dispatch and load update applied to the slot leaving the head of the ring
`default_nettype none
module ptts_slot_op #(
    parameter int CW = 16
) (
    input  wire logic [2*CW+1:0]       slot_in,
    input  wire ptts_pkg::op_ctrl_t    ctrl,
    input  wire logic [CW-1:0]         load_value,
    output logic      [2*CW+1:0]       slot_out,
    output logic                       fire
);

    logic [CW-1:0] cnt;
    logic [CW-1:0] ival;
    logic          susp;
    logic          pend;
    logic [CW-1:0] cnt_dec;
    logic [CW-1:0] cnt_new;
    logic [CW-1:0] ival_new;
    logic          susp_new;
    logic          pend_new;

    assign {cnt, ival, susp, pend} = slot_in;
    assign cnt_dec = cnt - CW'(1);

    always_comb begin
        cnt_new  = cnt;
        ival_new = ival;
        susp_new = susp;
        pend_new = pend;
        fire     = 1'b0;
        case (ctrl.mode)
            ptts_pkg::MODE_TICK: begin
                if (cnt != '0 && !susp) begin
                    if (cnt_dec == '0) begin
                        cnt_new  = ival;
                        pend_new = 1'b1;
                    end else begin
                        cnt_new = cnt_dec;
                    end
                end
            end
            ptts_pkg::MODE_DISPATCH: begin
                if (pend && !susp && ctrl.can_dispatch) begin
                    pend_new = 1'b0;
                    fire     = 1'b1;
                end
            end
            ptts_pkg::MODE_LOAD: begin
                if (ctrl.load_hit) begin
                    cnt_new  = load_value;
                    ival_new = load_value;
                    susp_new = ctrl.load_suspend;
                    pend_new = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    assign slot_out = {cnt_new, ival_new, susp_new, pend_new};

endmodule
`default_nettype wire

>>> verif/tb_top.sv
// testbench for the periodic task tick scheduler: directed and random load, tick and dispatch beats
`timescale 1ns / 100ps
module tb_top;

    localparam int SLOTS       = 16;
    localparam int COUNT_W     = 16;
    localparam int IDLE_LIMIT  = 3000;
    localparam int RAND_BEATS  = 100;
    localparam int HOLD_CYCLES = 300;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    ptts_pkg::in_beat_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    ptts_pkg::out_beat_t m_data;

    periodic_task_tick_scheduler #(
        .NUM_SLOTS  (SLOTS),
        .COUNT_WIDTH(COUNT_W)
    ) u_top (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // slot table mirror
    logic [COUNT_W-1:0] slot_count  [SLOTS];
    logic [COUNT_W-1:0] slot_reload [SLOTS];
    logic               slot_susp   [SLOTS];
    logic               slot_pend   [SLOTS];

    ptts_pkg::in_beat_t  beat_q[$];
    ptts_pkg::out_beat_t dispatch_q[$];

    int n_accepted = 0;
    int n_ticks = 0;
    int n_dispatches = 0;
    int n_loads = 0;
    int n_ignored = 0;
    int n_full_passes = 0;
    int n_empty_passes = 0;
    int n_checked = 0;
    int err_cnt = 0;
    int idle_cyc = 0;
    logic hold_off = 1'b0;

    task automatic update_slots(input ptts_pkg::in_beat_t b);
        logic [4:0]          sl;
        int                  hits [SLOTS];
        int                  n;
        ptts_pkg::out_beat_t r;
        case (b.mode)
            ptts_pkg::MODE_TICK: begin
                n_ticks++;
                for (sl = 0; sl < SLOTS; sl++) begin
                    if (slot_count[sl] != '0 && !slot_susp[sl]) begin
                        slot_count[sl] = slot_count[sl] - 1'b1;
                        if (slot_count[sl] == '0) begin
                            slot_count[sl] = slot_reload[sl];
                            slot_pend[sl]  = 1'b1;
                        end
                    end
                end
            end
            ptts_pkg::MODE_DISPATCH: begin
                n_dispatches++;
                n = 0;
                for (sl = 0; sl < SLOTS && n < ptts_pkg::MAX_RESULTS; sl++) begin
                    if (slot_pend[sl] && !slot_susp[sl]) begin
                        slot_pend[sl] = 1'b0;
                        hits[n] = sl;
                        n++;
                    end
                end
                if (n == 0) begin
                    n_empty_passes++;
                    r.task_index = '0;
                    r.none_ready = 1'b1;
                    r.last       = 1'b1;
                    dispatch_q.push_back(r);
                end else begin
                    if (n == ptts_pkg::MAX_RESULTS) n_full_passes++;
                    for (int k = 0; k < n; k++) begin
                        r.task_index = hits[k][3:0];
                        r.none_ready = 1'b0;
                        r.last       = (k == n - 1);
                        dispatch_q.push_back(r);
                    end
                end
            end
            ptts_pkg::MODE_LOAD: begin
                n_loads++;
                if (b.slot_index < SLOTS) begin
                    slot_count[b.slot_index]  = b.interval_value;
                    slot_reload[b.slot_index] = b.interval_value;
                    slot_susp[b.slot_index]   = b.suspend_value;
                    slot_pend[b.slot_index]   = 1'b0;
                end
            end
            default: n_ignored++;
        endcase
    endtask

    function automatic ptts_pkg::in_beat_t make_beat(input logic [1:0] mode,
                                                     input logic [3:0] slot,
                                                     input logic [15:0] ival,
                                                     input logic susp);
        ptts_pkg::in_beat_t b;
        b.mode           = mode;
        b.slot_index     = slot;
        b.interval_value = ival;
        b.suspend_value  = susp;
        return b;
    endfunction

    // junk in the unused fields of tick and dispatch beats
    function automatic ptts_pkg::in_beat_t noisy_beat(input logic [1:0] mode);
        return make_beat(mode, 4'($urandom), 16'($urandom), 1'($urandom));
    endfunction

    function automatic logic [15:0] pick_interval();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'($urandom);
            2:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 5));
        endcase
    endfunction

    // driver: bursts of beats with random gaps between them
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                update_slots(s_data);
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (beat_q.size() != 0) begin
                    s_valid <= 1'b1;
                    s_data  <= beat_q.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(input string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("ERROR: %s", msg);
    endtask

    // monitor: check each result beat and drive the receiver stall pattern
    int rx_cyc = 0;
    always @(posedge aclk) begin
        ptts_pkg::out_beat_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_checked++;
                if (dispatch_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result beat idx=%0d none=%0b last=%0b",
                                              m_data.task_index, m_data.none_ready, m_data.last));
                end else begin
                    e = dispatch_q.pop_front();
                    if (m_data.task_index !== e.task_index || m_data.none_ready !== e.none_ready ||
                        m_data.last !== e.last)
                        report_mismatch($sformatf(
                            "result exp idx=%0d none=%0b last=%0b got idx=%0d none=%0b last=%0b",
                            e.task_index, e.none_ready, e.last,
                            m_data.task_index, m_data.none_ready, m_data.last));
                end
            end
            rx_cyc <= rx_cyc + 1;
            if (hold_off) begin
                m_ready <= 1'b0;
            end else begin
                case ((rx_cyc / 64) % 4)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom);
                    2:       m_ready <= (rx_cyc % 4 != 0);
                    default: m_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cyc <= 0;
        else idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= IDLE_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("tb_top failed");
            $finish;
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial begin
        wait (n_accepted >= 60);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        int n_rand;
        int pick;
        for (int s = 0; s < SLOTS; s++) begin
            slot_count[s]  = '0;
            slot_reload[s] = '0;
            slot_susp[s]   = 1'b0;
            slot_pend[s]   = 1'b0;
        end

        // directed: empty table, ignored mode, full pass, extremes, zero and suspended slots
        beat_q.push_back(noisy_beat(ptts_pkg::MODE_DISPATCH));
        beat_q.push_back(noisy_beat(ptts_pkg::MODE_TICK));
        beat_q.push_back(make_beat(ptts_pkg::MODE_UNUSED, 4'hF, 16'hFFFF, 1'b1));
        for (int s = 0; s < SLOTS; s++)
            beat_q.push_back(make_beat(ptts_pkg::MODE_LOAD, 4'(s), 16'd1, 1'b0));
        beat_q.push_back(noisy_beat(ptts_pkg::MODE_TICK));
        beat_q.push_back(noisy_beat(ptts_pkg::MODE_DISPATCH));
        beat_q.push_back(make_beat(ptts_pkg::MODE_LOAD, 4'd15, 16'hFFFF, 1'b0));
        beat_q.push_back(make_beat(ptts_pkg::MODE_LOAD, 4'd1, 16'd0, 1'b0));
        beat_q.push_back(make_beat(ptts_pkg::MODE_LOAD, 4'd2, 16'd1, 1'b1));
        beat_q.push_back(noisy_beat(ptts_pkg::MODE_TICK));
        beat_q.push_back(noisy_beat(ptts_pkg::MODE_DISPATCH));

        n_rand = 0;
        while (n_rand < RAND_BEATS) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // arm every slot, let them run, then dispatch
                for (int s = 0; s < SLOTS; s++)
                    beat_q.push_back(make_beat(ptts_pkg::MODE_LOAD, 4'(s),
                                               16'($urandom_range(1, 3)),
                                               ($urandom_range(0, 9) == 0)));
                pick = $urandom_range(1, 3);
                for (int k = 0; k < pick; k++)
                    beat_q.push_back(noisy_beat(ptts_pkg::MODE_TICK));
                beat_q.push_back(noisy_beat(ptts_pkg::MODE_DISPATCH));
                n_rand += SLOTS + pick + 1;
            end else if (pick < 38) begin
                beat_q.push_back(make_beat(ptts_pkg::MODE_LOAD, 4'($urandom), pick_interval(),
                                           ($urandom_range(0, 4) == 0)));
                n_rand++;
            end else if (pick < 68) begin
                beat_q.push_back(noisy_beat(ptts_pkg::MODE_TICK));
                n_rand++;
            end else if (pick < 93) begin
                beat_q.push_back(noisy_beat(ptts_pkg::MODE_DISPATCH));
                n_rand++;
            end else begin
                beat_q.push_back(noisy_beat(ptts_pkg::MODE_UNUSED));
            end
        end
        beat_q.push_back(noisy_beat(ptts_pkg::MODE_DISPATCH));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (beat_q.size() != 0 || s_valid) @(posedge aclk);
        while (dispatch_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (dispatch_q.size() != 0)
            report_mismatch($sformatf("%0d result beats never arrived", dispatch_q.size()));
        $display("run covered %0d beats: %0d ticks, %0d dispatches, %0d loads, %0d ignored",
                 n_accepted, n_ticks, n_dispatches, n_loads, n_ignored);
        $display("%0d result beats checked, %0d full passes, %0d empty passes, %0d errors",
                 n_checked, n_full_passes, n_empty_passes, err_cnt);
        if (err_cnt == 0) $display("tb_top passed");
        else $display("tb_top failed");
        $finish;
    end

endmodule
